/* sv/brf_pkg.sv */
// Shared types and constants for the byte ring FIFO with overwrite.
package brf_pkg;

  localparam int SLOTS_DEF = 1024;

  localparam int CAP_W    = 10;
  localparam int REQ_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int CLEN_W   = 16;
  localparam int OFFSET_W = 10;
  localparam int FILL_W   = 10;

  localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;
  localparam logic [CAP_W-1:0] CAP_MIN   = 10'd2;

  localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PEEK    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DISCARD = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PEEK
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the incoming item
    logic rd_en;     // read the store at the peek address
    logic upd;       // commit pointer and store changes
    logic out_load;  // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_peek;
  } dp_stat_t;

endpackage

/* sv/brf_ctrl.sv */
// Controller state machine for the byte ring FIFO: sequencing and output valid.
module brf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  brf_pkg::dp_stat_t stat_i,
  output brf_pkg::dp_cmd_t  cmd_o
);

  brf_pkg::ctl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brf_pkg::S_IDLE: begin
        if (in_valid_i) state_d = brf_pkg::S_EXEC;
      end
      brf_pkg::S_EXEC: begin
        if (stat_i.is_peek) begin
          state_d = brf_pkg::S_PEEK;
        end else if (slot_free) begin
          state_d = brf_pkg::S_IDLE;
        end
      end
      brf_pkg::S_PEEK: begin
        if (slot_free) state_d = brf_pkg::S_IDLE;
      end
      default: state_d = brf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      brf_pkg::S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      brf_pkg::S_EXEC: begin
        // A peek only reads here; everything else commits once the result slot is free.
        cmd_o.rd_en    = stat_i.is_peek;
        cmd_o.upd      = !stat_i.is_peek && slot_free;
        cmd_o.out_load = !stat_i.is_peek && slot_free;
      end
      brf_pkg::S_PEEK: begin
        cmd_o.out_load = slot_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brf_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/brf_datapath.sv */
// Datapath for the byte ring FIFO: pointers, capacity, byte store and result register.
module brf_datapath #(
  parameter int SLOTS = brf_pkg::SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brf_pkg::dp_cmd_t              cmd_i,
  output brf_pkg::dp_stat_t             stat_o,
  input  logic                          cfg_we_i,
  input  logic [brf_pkg::CAP_W-1:0]     cfg_data_i,
  input  logic [brf_pkg::REQ_W-1:0]     req_type_i,
  input  logic [brf_pkg::BYTE_W-1:0]    push_byte_i,
  input  logic                          chunk_first_i,
  input  logic [brf_pkg::CLEN_W-1:0]    chunk_length_i,
  input  logic                          overwrite_i,
  input  logic [brf_pkg::OFFSET_W-1:0]  read_offset_i,
  input  logic [brf_pkg::CAP_W-1:0]     discard_count_i,
  input  logic                          discard_all_i,
  output logic                          accepted_o,
  output logic                          dropped_oldest_o,
  output logic [brf_pkg::BYTE_W-1:0]    read_data_o,
  output logic                          read_valid_o,
  output logic [brf_pkg::FILL_W-1:0]    fill_count_o,
  output logic [brf_pkg::FILL_W-1:0]    space_left_o
);

  localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = (PW + 1 > 11) ? PW + 1 : 11;
  localparam int LW = (EW > brf_pkg::CLEN_W) ? EW : brf_pkg::CLEN_W;

  // Control state.
  logic [brf_pkg::CAP_W-1:0] cap_q;
  logic [PW-1:0]             head_q, head_d;
  logic [PW-1:0]             tail_q, tail_d;
  logic                      rej_q, rej_d;

  // Captured item.
  logic [brf_pkg::REQ_W-1:0]    req_q;
  logic [brf_pkg::BYTE_W-1:0]   pbyte_q;
  logic                         first_q;
  logic [brf_pkg::CLEN_W-1:0]   clen_q;
  logic                         ovw_q;
  logic [brf_pkg::OFFSET_W-1:0] roff_q;
  logic [brf_pkg::CAP_W-1:0]    dcnt_q;
  logic                         dall_q;

  logic [brf_pkg::BYTE_W-1:0] mem [SLOTS];
  logic [brf_pkg::BYTE_W-1:0] mem_rd_q;

  logic [EW-1:0] cap_ext, cap, ring, head_e, tail_e, fill, space, fill_new;
  logic [EW-1:0] head_nxt, tail_nxt, peek_sum, disc_sum;
  logic [PW-1:0] head_inc, tail_inc, peek_addr, disc_head;
  logic          rej_eff, full, push_ok, drop, acc, rvalid, wr_en;

  // Result register.
  logic                       acc_q, drop_q, rvalid_q;
  logic [brf_pkg::BYTE_W-1:0] rdata_q;
  logic [brf_pkg::FILL_W-1:0] fill_out_q, space_out_q;

  function automatic logic [brf_pkg::FILL_W-1:0] FILL_W_CAST(input logic [EW-1:0] v);
    return v[brf_pkg::FILL_W-1:0];
  endfunction

  always_comb begin
    cap_ext = EW'(cap_q);
    if (cap_ext < EW'(brf_pkg::CAP_MIN)) begin
      cap = EW'(brf_pkg::CAP_MIN);
    end else if (cap_ext > EW'(SLOTS - 1)) begin
      cap = EW'(SLOTS - 1);
    end else begin
      cap = cap_ext;
    end
    ring   = cap + EW'(1);
    head_e = EW'(head_q);
    tail_e = EW'(tail_q);
    if (tail_e >= head_e) begin
      fill = tail_e - head_e;
    end else begin
      fill = tail_e + ring - head_e;
    end
    space = cap - fill;

    head_nxt = head_e + EW'(1);
    tail_nxt = tail_e + EW'(1);
    head_inc = (head_nxt == ring) ? '0 : head_nxt[PW-1:0];
    tail_inc = (tail_nxt == ring) ? '0 : tail_nxt[PW-1:0];

    // Offsets are below the fill level where used, so one subtract wraps them.
    peek_sum  = head_e + EW'(roff_q);
    peek_addr = (peek_sum >= ring) ? PW'(peek_sum - ring) : peek_sum[PW-1:0];
    disc_sum  = head_e + EW'(dcnt_q);
    disc_head = (disc_sum >= ring) ? PW'(disc_sum - ring) : disc_sum[PW-1:0];
  end

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    rej_d    = rej_q;
    rej_eff  = rej_q;
    full     = fill >= cap;
    push_ok  = 1'b0;
    drop     = 1'b0;
    acc      = 1'b0;
    rvalid   = 1'b0;
    wr_en    = 1'b0;
    fill_new = fill;
    unique case (req_q)
      brf_pkg::REQ_PUSH: begin
        if (first_q) begin
          rej_eff = (clen_q == '0) || (!ovw_q && (LW'(space) < LW'(clen_q)));
        end
        rej_d = rej_eff;
        if (!rej_eff) begin
          push_ok = !full || ovw_q;
          drop    = full && ovw_q;
          if (drop) head_d = head_inc;
          if (push_ok) begin
            wr_en    = 1'b1;
            tail_d   = tail_inc;
            acc      = 1'b1;
            fill_new = drop ? fill : fill + EW'(1);
          end
        end
      end
      brf_pkg::REQ_PEEK: begin
        acc    = 1'b1;
        rvalid = EW'(roff_q) < fill;
      end
      brf_pkg::REQ_DISCARD: begin
        acc = 1'b1;
        if (dall_q || (EW'(dcnt_q) >= fill)) begin
          head_d   = tail_q;
          fill_new = '0;
        end else begin
          head_d   = disc_head;
          fill_new = fill - EW'(dcnt_q);
        end
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  assign stat_o.is_peek = (req_q == brf_pkg::REQ_PEEK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= brf_pkg::CAP_RESET;
      head_q <= '0;
      tail_q <= '0;
      rej_q  <= 1'b0;
    end else if (cfg_we_i) begin
      cap_q  <= cfg_data_i;
      head_q <= '0;
      tail_q <= '0;
      rej_q  <= 1'b0;
    end else if (cmd_i.upd) begin
      head_q <= head_d;
      tail_q <= tail_d;
      rej_q  <= rej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q   <= req_type_i;
      pbyte_q <= push_byte_i;
      first_q <= chunk_first_i;
      clen_q  <= chunk_length_i;
      ovw_q   <= overwrite_i;
      roff_q  <= read_offset_i;
      dcnt_q  <= discard_count_i;
      dall_q  <= discard_all_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && wr_en) begin
      mem[tail_q] <= pbyte_q;
    end
    if (cmd_i.rd_en) begin
      mem_rd_q <= mem[peek_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      acc_q       <= acc;
      drop_q      <= drop;
      rvalid_q    <= rvalid;
      rdata_q     <= rvalid ? mem_rd_q : '0;
      fill_out_q  <= fill_new[brf_pkg::FILL_W-1:0];
      space_out_q <= FILL_W_CAST(cap - fill_new);
    end
  end

  assign accepted_o       = acc_q;
  assign dropped_oldest_o = drop_q;
  assign read_valid_o     = rvalid_q;
  assign read_data_o      = rdata_q;
  assign fill_count_o     = fill_out_q;
  assign space_left_o     = space_out_q;

endmodule

/* sv/byte_ring_fifo_overwrite.sv */
// Top level of the byte ring FIFO with overwrite: controller, datapath and checks.
// A circular byte queue holding up to the capacity register's value (clamped to 2..SLOTS-1)
// in a ring of capacity+1 slots. Each item pushes a byte, peeks a byte at an offset from
// the head, or discards bytes from the head, and gives exactly one result item carrying
// the fill level and free space afterward. An item is captured in S_IDLE. A push or discard
// commits and loads its result in S_EXEC; a peek reads the store's one registered read port
// in S_EXEC and loads its result in S_PEEK, each once the output register is free. One item
// is in work at a time; a finished result waits in an output register while the next item
// is accepted. Writing capacity empties the queue and must happen only while the block is
// idle. No clearing pass follows reset: the pointers alone define what the store holds.
module byte_ring_fifo_overwrite #(
  parameter int SLOTS = brf_pkg::SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brf_pkg::CAP_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [brf_pkg::REQ_W-1:0]     req_type_i,
  input  logic [brf_pkg::BYTE_W-1:0]    push_byte_i,
  input  logic                          chunk_first_i,
  input  logic [brf_pkg::CLEN_W-1:0]    chunk_length_i,
  input  logic                          overwrite_i,
  input  logic [brf_pkg::OFFSET_W-1:0]  read_offset_i,
  input  logic [brf_pkg::CAP_W-1:0]     discard_count_i,
  input  logic                          discard_all_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic                          dropped_oldest_o,
  output logic [brf_pkg::BYTE_W-1:0]    read_data_o,
  output logic                          read_valid_o,
  output logic [brf_pkg::FILL_W-1:0]    fill_count_o,
  output logic [brf_pkg::FILL_W-1:0]    space_left_o
);

  brf_pkg::dp_cmd_t  cmd;
  brf_pkg::dp_stat_t stat;

  brf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  brf_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .push_byte_i      (push_byte_i),
    .chunk_first_i    (chunk_first_i),
    .chunk_length_i   (chunk_length_i),
    .overwrite_i      (overwrite_i),
    .read_offset_i    (read_offset_i),
    .discard_count_i  (discard_count_i),
    .discard_all_i    (discard_all_i),
    .accepted_o       (accepted_o),
    .dropped_oldest_o (dropped_oldest_o),
    .read_data_o      (read_data_o),
    .read_valid_o     (read_valid_o),
    .fill_count_o     (fill_count_o),
    .space_left_o     (space_left_o)
  );

  // In the cycle after an item is taken, the block stalls its input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while previous item still in work");

  // Only a stored byte can have displaced the oldest one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_oldest_o) |-> accepted_o)
    else $error("oldest byte dropped without storing the new one");

  // A valid peek is always a completed request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_valid_o) |-> (accepted_o && !dropped_oldest_o))
    else $error("peek result carries inconsistent flags");

  // Peek data is zero unless the peek hit a stored byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !read_valid_o) |-> (read_data_o == '0))
    else $error("read data nonzero on an invalid peek");

endmodule
